>>> rtl/leap_second_offset_table_top_macros.svh
// ----------------------------------------------------------------------------
// Leap-second offset table assertion macros
// Shared assertion wrappers. Defining ASSERT_OFF compiles every check away.
// ----------------------------------------------------------------------------
`ifndef LEAP_SECOND_OFFSET_TABLE_TOP_MACROS_SVH
`define LEAP_SECOND_OFFSET_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent property: prop must hold at every clock edge out of reset.
`define LSOT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Next-cycle property: when ante holds, cons must hold at the next clock edge.
`define LSOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSOT_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/lsot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leap-second offset table package
// Command and status codes, register indexes, sequencer states, the row
// layout and the calendar constants shared by the table and its multiplier.
// ----------------------------------------------------------------------------
package lsot_pkg;

	// Input commands.
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_LOAD    = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;
	localparam logic [1:0] CMD_DAY_END = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_FRACTIONAL = 3'd1;
	localparam logic [2:0] STAT_MISMATCH   = 3'd2;
	localparam logic [2:0] STAT_NOT_INCR   = 3'd3;
	localparam logic [2:0] STAT_FULL       = 3'd4;
	localparam logic [2:0] STAT_BEFORE     = 3'd5;
	localparam logic [2:0] STAT_EXPIRED    = 3'd6;
	localparam logic [2:0] STAT_EMPTY      = 3'd7;

	// Configuration register indexes.
	localparam logic REG_EXPIRY_DAY    = 1'b0;
	localparam logic REG_IGNORE_EXPIRY = 1'b1;

	// Calendar arithmetic. The MJD bias folds the Julian day base (32045) and
	// the JD-to-MJD shift (2400001) into one subtraction.
	localparam logic [14:0] YEAR_SHIFT   = 15'd4800;
	localparam logic [15:0] DAYS_IN_YEAR = 16'd365;
	localparam logic [15:0] RECIP_25     = 16'd5243;   // ceil(2^17 / 25)
	localparam logic [25:0] MJD_BIAS     = 26'd2432046;

	localparam logic [15:0] OFFSET_MAX = 16'h7FFF;
	localparam logic [15:0] OFFSET_MIN = 16'h8000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GREG_MUL,
		ST_GREG_ACC,
		ST_GREG_DIV,
		ST_LOAD_CHK,
		ST_SRCH_START,
		ST_SRCH,
		ST_FETCH,
		ST_PREV,
		ST_DONE
	} state_t;

	// One table row: start day (MJD) and whole-second offset bits.
	typedef struct packed {
		logic [23:0] start_day;
		logic [15:0] offset;
	} row_t;

	// Request to the shared multiplier.
	typedef struct packed {
		logic        en;
		logic [15:0] a;
		logic [15:0] b;
	} mul_req_t;

	// Days before the first of a shifted month (year starting in March):
	// (153 * mm + 2) / 5 for mm = 0..12.
	function automatic logic [8:0] month_base(input logic [3:0] mm);
		logic [8:0] r;
		case (mm)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/lsot_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leap-second table shared multiplier
// One 16 x 16 unsigned multiplier with a registered product, reused by the
// sequencer for every product of the date conversion.
// ----------------------------------------------------------------------------
module lsot_mul (
	input  logic                clk,
	input  lsot_pkg::mul_req_t  req,
	output logic [31:0]         prod
);

	logic [31:0] prod_q;

	// The product holds until the next request, so it can be read at leisure.
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= {16'b0, req.a} * {16'b0, req.b};
		end
	end

	assign prod = prod_q;

endmodule

>>> rtl/leap_second_offset_table_top.sv
`timescale 1ns / 1ps
// The search reads one table row per cycle through the single registered memory read port.
// One item is in work at a time: the next input transfer is taken in the cycle after the result
//   moves to the output register.
// Reset empties the table and clears both configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Leap-second offset table
// Sorted table of leap-second rows with load checks, offset lookup by
// upper-bound binary search, and the day-end leap query.
// ----------------------------------------------------------------------------
`include "leap_second_offset_table_top_macros.svh"

module leap_second_offset_table_top #(
	parameter int          TABLE_DEPTH         = 64,
	parameter logic [23:0] FIRST_SUPPORTED_DAY = 24'd41317
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Configuration write port
	input  logic                                    cfg_write_en,
	input  logic                                    cfg_index,
	input  logic [23:0]                             cfg_data,
	// Input channel
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [1:0]                              command,
	input  logic [23:0]                             day_number,
	input  logic [4:0]                              row_day,
	input  logic [3:0]                              row_month,
	input  logic [13:0]                             row_year,
	input  logic signed [15:0]                      row_offset,
	input  logic                                    offset_fractional,
	// Output channel
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [2:0]                              status,
	output logic signed [15:0]                      value,
	output logic [$clog2(TABLE_DEPTH + 1) - 1:0]    row_count
);

	// Row index width and row count width (the count can equal the depth).
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// ------------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------------
	lsot_pkg::state_t state_q, state_d;

	// Control state, cleared by reset.
	logic [CW-1:0]  rows_held_q;
	logic [23:0]    expiry_q;
	logic           ignore_q;
	logic           out_valid_q;

	// Item being worked on. The key is the queried day, or the next day for a
	// day-end query, so it needs one bit beyond the day field.
	logic [1:0]         cmd_q;
	logic [23:0]        day_q;
	logic [24:0]        key_q;
	logic [4:0]         dom_q;
	logic [3:0]         mon_q;
	logic [13:0]        year_q;
	logic [15:0]        offset_q;

	// Search window and probe.
	logic [CW-1:0]      lo_q, hi_q, mid_q;

	// Running MJD sum of the date conversion, kept modulo 2^26. Its true value
	// stays well inside that range, so equality with the day is exact.
	logic [25:0]        acc_q;

	// Offset of the row that starts on the day after a day-end query.
	logic [15:0]        off_i_q;

	// Result waiting for the output register, and the output register.
	logic [2:0]         res_status_q;
	logic [15:0]        res_value_q;
	logic [2:0]         out_status_q;
	logic [15:0]        out_value_q;
	logic [CW-1:0]      out_count_q;

	// Table memory with one write port and one registered read port.
	lsot_pkg::row_t     mem_q [TABLE_DEPTH];
	lsot_pkg::row_t     rd_q;

	// ------------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------------
	logic in_xfer;
	logic out_free;

	// The block takes an item only when its sequencer is idle. A finished
	// result moves to the output register as soon as that register is empty
	// or its current transfer completes in the same cycle.
	assign in_stall = (state_q != lsot_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ------------------------------------------------------------------------
	// Checks made when an item is taken
	// ------------------------------------------------------------------------
	// Clears, fractional loads at or after the first supported day, and
	// queries that are refused finish at once with a status. Everything else
	// goes on to the date conversion or the table search.
	logic       acc_finish;
	logic [2:0] acc_status;

	always_comb begin
		acc_finish = 1'b0;
		acc_status = lsot_pkg::STAT_OK;
		case (command)
			lsot_pkg::CMD_CLEAR: begin
				acc_finish = 1'b1;
			end
			lsot_pkg::CMD_LOAD: begin
				if (offset_fractional && (day_number >= FIRST_SUPPORTED_DAY)) begin
					acc_finish = 1'b1;
					acc_status = lsot_pkg::STAT_FRACTIONAL;
				end
			end
			lsot_pkg::CMD_QUERY: begin
				acc_finish = 1'b1;
				if (day_number < FIRST_SUPPORTED_DAY) begin
					acc_status = lsot_pkg::STAT_BEFORE;
				end else if ((expiry_q != 24'd0) && (day_number > expiry_q) && !ignore_q) begin
					acc_status = lsot_pkg::STAT_EXPIRED;
				end else if (rows_held_q == '0) begin
					acc_status = lsot_pkg::STAT_EMPTY;
				end else begin
					acc_finish = 1'b0;
				end
			end
			default: begin
				// The day-end query is never refused; it always searches.
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Date conversion datapath
	// ------------------------------------------------------------------------
	// The year is shifted to start in March: January and February (and the
	// meaningless month zero) belong to the year before. Month numbers above
	// twelve are not rejected; they run on past December into the next year.
	logic           early_month;
	logic [14:0]    shifted_year;
	logic [3:0]     shifted_month;
	logic [12:0]    year_div4;
	logic [31:0]    prod;
	logic [7:0]     year_div100;
	logic [5:0]     year_div400;
	logic           greg_match;

	assign early_month   = (mon_q <= 4'd2);
	assign shifted_year  = {1'b0, year_q} + lsot_pkg::YEAR_SHIFT - {14'b0, early_month};
	assign shifted_month = early_month ? (mon_q + 4'd9) : (mon_q - 4'd3);
	assign year_div4     = shifted_year[14:2];
	// (year / 4) * ceil(2^17 / 25) >> 17 is exactly year / 100 over the
	// range of the shifted year, and a further shift by two gives year / 400.
	assign year_div100   = prod[24:17];
	assign year_div400   = year_div100[7:2];
	assign greg_match    = (acc_q == {2'b00, day_q});

	// ------------------------------------------------------------------------
	// Search datapath
	// ------------------------------------------------------------------------
	// Upper-bound search: the window [lo, hi) shrinks toward the first row
	// whose start day is after the key. The probe read issued in one cycle is
	// compared in the next, and the next probe is issued at once.
	logic           go_left;
	logic [CW-1:0]  lo_n, hi_n, mid_n, fetch_n, prev_idx;
	logic           day_end_hit;
	logic [16:0]    leap_diff;
	logic [15:0]    leap_sat;

	always_comb begin
		go_left = (key_q < {1'b0, rd_q.start_day});
		if (state_q == lsot_pkg::ST_SRCH) begin
			lo_n = go_left ? lo_q : (mid_q + 1'b1);
			hi_n = go_left ? mid_q : hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = hi_q;
		end
		mid_n   = lo_n + ((hi_n - lo_n) >> 1);
		// Row that holds the answer: the last row not after the key, or the
		// first row when the key lies before the whole table.
		fetch_n = (lo_n == '0) ? '0 : (lo_n - 1'b1);
		prev_idx = lo_q - CW'(2);
	end

	// A day-end query has a leap when a row other than the first starts on
	// the next day. Row starts strictly increase, so that row is unique.
	assign day_end_hit = (lo_q >= CW'(2)) && ({1'b0, rd_q.start_day} == key_q);

	// Leap size: that row's offset minus the one before, saturated.
	assign leap_diff = {off_i_q[15], off_i_q} - {rd_q.offset[15], rd_q.offset};
	assign leap_sat  = (leap_diff[16] != leap_diff[15])
		? (leap_diff[16] ? lsot_pkg::OFFSET_MIN : lsot_pkg::OFFSET_MAX)
		: leap_diff[15:0];

	// Load checks after the date conversion, in their order of priority.
	logic [2:0] load_status;

	always_comb begin
		if (!greg_match) begin
			load_status = lsot_pkg::STAT_MISMATCH;
		end else if ((rows_held_q != '0) && (day_q <= rd_q.start_day)) begin
			load_status = lsot_pkg::STAT_NOT_INCR;
		end else if (rows_held_q >= CW'(TABLE_DEPTH)) begin
			load_status = lsot_pkg::STAT_FULL;
		end else begin
			load_status = lsot_pkg::STAT_OK;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsot_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (acc_finish) begin
						state_d = lsot_pkg::ST_DONE;
					end else if (command == lsot_pkg::CMD_LOAD) begin
						state_d = lsot_pkg::ST_GREG_MUL;
					end else begin
						state_d = lsot_pkg::ST_SRCH_START;
					end
				end
			end
			lsot_pkg::ST_GREG_MUL:   state_d = lsot_pkg::ST_GREG_ACC;
			lsot_pkg::ST_GREG_ACC:   state_d = lsot_pkg::ST_GREG_DIV;
			lsot_pkg::ST_GREG_DIV:   state_d = lsot_pkg::ST_LOAD_CHK;
			lsot_pkg::ST_LOAD_CHK:   state_d = lsot_pkg::ST_DONE;
			lsot_pkg::ST_SRCH_START, lsot_pkg::ST_SRCH: begin
				state_d = (lo_n < hi_n) ? lsot_pkg::ST_SRCH : lsot_pkg::ST_FETCH;
			end
			lsot_pkg::ST_FETCH: begin
				state_d = ((cmd_q == lsot_pkg::CMD_DAY_END) && day_end_hit)
					? lsot_pkg::ST_PREV : lsot_pkg::ST_DONE;
			end
			lsot_pkg::ST_PREV:       state_d = lsot_pkg::ST_DONE;
			lsot_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lsot_pkg::ST_IDLE;
				end
			end
			default:                 state_d = lsot_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------------
	logic [AW-1:0]       rd_addr;
	logic                mem_we;
	logic                out_load;
	lsot_pkg::mul_req_t  mul_req;

	always_comb begin
		rd_addr  = '0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		mul_req  = '0;
		case (state_q)
			lsot_pkg::ST_GREG_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = {1'b0, shifted_year};
				mul_req.b  = lsot_pkg::DAYS_IN_YEAR;
			end
			lsot_pkg::ST_GREG_ACC: begin
				mul_req.en = 1'b1;
				mul_req.a  = {3'b0, year_div4};
				mul_req.b  = lsot_pkg::RECIP_25;
			end
			lsot_pkg::ST_GREG_DIV: begin
				// Last row, for the increasing-day check.
				rd_addr = AW'(rows_held_q - 1'b1);
			end
			lsot_pkg::ST_LOAD_CHK: begin
				mem_we = (load_status == lsot_pkg::STAT_OK);
			end
			lsot_pkg::ST_SRCH_START, lsot_pkg::ST_SRCH: begin
				rd_addr = (lo_n < hi_n) ? AW'(mid_n) : AW'(fetch_n);
			end
			lsot_pkg::ST_FETCH: begin
				rd_addr = AW'(prev_idx);
			end
			lsot_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Shared multiplier
	// ------------------------------------------------------------------------
	lsot_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// ------------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsot_pkg::ST_IDLE;
			rows_held_q <= '0;
			expiry_q    <= '0;
			ignore_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (in_xfer && (command == lsot_pkg::CMD_CLEAR)) begin
				rows_held_q <= '0;
			end else if (mem_we) begin
				rows_held_q <= rows_held_q + 1'b1;
			end

			if (cfg_write_en) begin
				case (cfg_index)
					lsot_pkg::REG_EXPIRY_DAY:    expiry_q <= cfg_data;
					lsot_pkg::REG_IGNORE_EXPIRY: ignore_q <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Item and result registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			lsot_pkg::ST_IDLE: begin
				if (in_xfer) begin
					cmd_q        <= command;
					day_q        <= day_number;
					key_q        <= {1'b0, day_number} +
						{24'b0, (command == lsot_pkg::CMD_DAY_END)};
					dom_q        <= row_day;
					mon_q        <= row_month;
					year_q       <= row_year;
					offset_q     <= row_offset;
					lo_q         <= '0;
					hi_q         <= rows_held_q;
					mid_q        <= rows_held_q >> 1;
					res_status_q <= acc_status;
					res_value_q  <= '0;
				end
			end
			lsot_pkg::ST_GREG_ACC: begin
				// d + month base + 365 * year + year / 4 - bias
				acc_q <= {2'b0, prod[23:0]} + {21'b0, dom_q} +
					{17'b0, lsot_pkg::month_base(shifted_month)} +
					{13'b0, year_div4} - lsot_pkg::MJD_BIAS;
			end
			lsot_pkg::ST_GREG_DIV: begin
				acc_q <= acc_q - {18'b0, year_div100} + {20'b0, year_div400};
			end
			lsot_pkg::ST_LOAD_CHK: begin
				res_status_q <= load_status;
			end
			lsot_pkg::ST_SRCH_START, lsot_pkg::ST_SRCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
			lsot_pkg::ST_FETCH: begin
				if (cmd_q == lsot_pkg::CMD_QUERY) begin
					res_value_q <= rd_q.offset;
				end else begin
					off_i_q <= rd_q.offset;
				end
			end
			lsot_pkg::ST_PREV: begin
				res_value_q <= leap_sat;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_count_q  <= rows_held_q;
		end
	end

	// ------------------------------------------------------------------------
	// Table memory
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[AW'(rows_held_q)] <= {day_q, offset_q};
		end
		rd_q <= mem_q[rd_addr];
	end

	// ------------------------------------------------------------------------
	// Output ports
	// ------------------------------------------------------------------------
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign value     = out_value_q;
	assign row_count = out_count_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`LSOT_ASSERT(a_rows_bound, clk, arst_n, rows_held_q <= CW'(TABLE_DEPTH), "row count exceeds table depth")
	`LSOT_ASSERT(a_write_room, clk, arst_n, mem_we |-> (rows_held_q < CW'(TABLE_DEPTH)), "row written to a full table")
	`LSOT_ASSERT_NEXT(a_write_count, clk, arst_n, mem_we, rows_held_q == ($past(rows_held_q) + 1'b1), "row count did not follow a row write")
	`LSOT_ASSERT(a_search_window, clk, arst_n, (state_q == lsot_pkg::ST_SRCH) |-> ((lo_q < hi_q) && (hi_q <= rows_held_q)), "search window outside the table")

endmodule
